// ===== src/dompid_pkg.sv =====
// Package for the derivative-on-measurement PID block: word types, register
// indexes and reset values, controller states, datapath opcodes, saturation helpers.
// No dependencies.
`default_nettype none

package dompid_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int LIMIT_WIDTH = 31;
  localparam int CFG_IDX_W   = 3;
  localparam int DIV_STEPS   = 32;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd5;

  localparam logic [VALUE_WIDTH-1:0] RST_GAIN_P         = 32'd65536;
  localparam logic [VALUE_WIDTH-1:0] RST_GAIN_I         = 32'd1311;
  localparam logic [VALUE_WIDTH-1:0] RST_GAIN_D         = 32'd524288;
  localparam logic [VALUE_WIDTH-1:0] RST_PERIOD         = 32'd16777;
  localparam logic [LIMIT_WIDTH-1:0] RST_ERROR_LIMIT    = 31'd6553600;
  localparam logic [LIMIT_WIDTH-1:0] RST_INTEGRAL_LIMIT = 31'd163840000;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] setpoint;
    logic signed [VALUE_WIDTH-1:0] feedback;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] drive;
    logic signed [VALUE_WIDTH-1:0] integral_term;
    logic                          integral_clamped;
  } out_word_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] gain_p;
    logic signed [VALUE_WIDTH-1:0] gain_i;
    logic signed [VALUE_WIDTH-1:0] gain_d;
    logic        [VALUE_WIDTH-1:0] period;
    logic        [LIMIT_WIDTH-1:0] error_limit;
    logic        [LIMIT_WIDTH-1:0] integral_limit;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLAMP,
    OP_MUL_P,
    OP_FIN_P,
    OP_MUL_GE,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_ADD_HI,
    OP_FIN_I,
    OP_ACC_I,
    OP_MUL_D,
    OP_DIV_PRE,
    OP_DIV_STEP,
    OP_FIN_D
  } dp_op_t;

  typedef struct packed {
    logic   load;
    logic   emit;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic period_zero;
    logic out_full;
  } sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_MUL_P,
    ST_FIN_P,
    ST_MUL_GE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD_HI,
    ST_FIN_I,
    ST_ACC_I,
    ST_MUL_D,
    ST_DIV_PRE,
    ST_DIV,
    ST_FIN_D,
    ST_DRIVE
  } st_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] u;
    u = v;
    return v[31] ? (~u + 32'd1) : u;
  endfunction

  // sign and magnitude to signed 32, saturating
  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [56:0] m);
    logic [31:0] lo;
    lo = m[31:0];
    if (neg) begin
      if (m > 57'h0_8000_0000) return 32'sh8000_0000;
      return $signed(~lo + 32'd1);
    end
    if (m > 57'h0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    return $signed(lo);
  endfunction

  function automatic logic signed [31:0] sat_wide(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < 34'sh3_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/dompid_ctrl.sv =====
// Sequencer for the PID datapath: walks the clamp, multiply, round, integrate and divide steps.
// Depends on dompid_pkg.
`default_nettype none

module dompid_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dompid_pkg::sts_t  sts,
  output dompid_pkg::cmd_t  cmd
);
  import dompid_pkg::*;

  st_t                  state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_CLAMP;
      ST_CLAMP:   state_nxt = ST_MUL_P;
      ST_MUL_P:   state_nxt = ST_FIN_P;
      ST_FIN_P:   state_nxt = ST_MUL_GE;
      ST_MUL_GE:  state_nxt = ST_MUL_LO;
      ST_MUL_LO:  state_nxt = ST_MUL_HI;
      ST_MUL_HI:  state_nxt = ST_ADD_HI;
      ST_ADD_HI:  state_nxt = ST_FIN_I;
      ST_FIN_I:   state_nxt = ST_ACC_I;
      ST_ACC_I:   state_nxt = sts.period_zero ? ST_FIN_D : ST_MUL_D;
      ST_MUL_D:   state_nxt = ST_DIV_PRE;
      ST_DIV_PRE: state_nxt = ST_DIV;
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_FIN_D;
      end
      ST_FIN_D:   state_nxt = ST_DRIVE;
      ST_DRIVE:   if (!sts.out_full) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    cmd.load = in_ready && in_valid;
    cmd.emit = (state_r == ST_DRIVE) && !sts.out_full;
    unique case (state_r)
      ST_CLAMP:   cmd.op = OP_CLAMP;
      ST_MUL_P:   cmd.op = OP_MUL_P;
      ST_FIN_P:   cmd.op = OP_FIN_P;
      ST_MUL_GE:  cmd.op = OP_MUL_GE;
      ST_MUL_LO:  cmd.op = OP_MUL_LO;
      ST_MUL_HI:  cmd.op = OP_MUL_HI;
      ST_ADD_HI:  cmd.op = OP_ADD_HI;
      ST_FIN_I:   cmd.op = OP_FIN_I;
      ST_ACC_I:   cmd.op = OP_ACC_I;
      ST_MUL_D:   cmd.op = OP_MUL_D;
      ST_DIV_PRE: cmd.op = OP_DIV_PRE;
      ST_DIV:     cmd.op = OP_DIV_STEP;
      ST_FIN_D:   cmd.op = OP_FIN_D;
      default:    cmd.op = OP_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/dompid_dpath.sv =====
// PID datapath: shared 32x32 multiplier, rounding and saturation, restoring
// divider for the derivative, integrator and output register. Depends on dompid_pkg.
`default_nettype none

module dompid_dpath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dompid_pkg::cfg_regs_t  cfg,
  input  dompid_pkg::in_word_t   in_word,
  input  dompid_pkg::cmd_t       cmd,
  output dompid_pkg::sts_t       sts,
  input  logic                   out_ready,
  output logic                   out_valid,
  output dompid_pkg::out_word_t  out_word
);
  import dompid_pkg::*;

  logic signed [31:0] err_r, ec_r, prop_r, incr_r, deriv_r, acc_r, prev_fb_r;
  logic        [31:0] dmag_r, ge_hi_r, rem_r, quo_r;
  logic               dneg_r, ge_neg_r, ovf_r, clamped_r, out_valid_r;
  logic        [63:0] prod_r;
  logic        [95:0] w_r;
  out_word_t          out_word_r;

  logic signed [32:0] diff33, delta33, delta_neg33, sum33, il33;
  logic        [31:0] dmag, mul_a, mul_b;
  logic        [63:0] mul_p;
  logic signed [31:0] el, ec_nxt, acc_nxt;
  logic               clamp_nxt;
  logic               p_neg, d_neg;
  logic        [56:0] p_m, i_m, d_m;
  logic        [39:0] hi40;
  logic        [32:0] div_t, div_sub;
  logic               div_ge;
  logic signed [33:0] drive34;

  assign diff33      = {in_word.setpoint[31], in_word.setpoint}
                     - {in_word.feedback[31], in_word.feedback};
  assign delta33     = {in_word.feedback[31], in_word.feedback} - {prev_fb_r[31], prev_fb_r};
  assign delta_neg33 = -delta33;
  assign dmag        = delta33[32] ? delta_neg33[31:0] : delta33[31:0];

  always_comb begin
    case (cmd.op)
      OP_MUL_GE: begin
        mul_a = mag32(cfg.gain_i);
        mul_b = mag32(ec_r);
      end
      OP_MUL_LO: begin
        mul_a = prod_r[31:0];
        mul_b = cfg.period;
      end
      OP_MUL_HI: begin
        mul_a = ge_hi_r;
        mul_b = cfg.period;
      end
      OP_MUL_D: begin
        mul_a = mag32(cfg.gain_d);
        mul_b = dmag_r;
      end
      default: begin
        mul_a = mag32(cfg.gain_p);
        mul_b = mag32(err_r);
      end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // error clamp for the integrator
  assign el = $signed({1'b0, cfg.error_limit});
  always_comb begin
    if (err_r > el)       ec_nxt = el;
    else if (err_r < -el) ec_nxt = -el;
    else                  ec_nxt = err_r;
  end

  // floor rounding in sign-magnitude: bump the magnitude when negative and inexact
  assign p_neg = cfg.gain_p[31] ^ err_r[31];
  assign p_m   = {9'd0, prod_r[63:16]} + 57'(p_neg && (prod_r[15:0] != '0));
  assign i_m   = {1'b0, w_r[95:40]} + 57'(ge_neg_r && (w_r[39:0] != '0));

  assign hi40    = prod_r[63:24];
  assign div_t   = {rem_r, quo_r[31]};
  assign div_ge  = div_t >= {1'b0, cfg.period};
  assign div_sub = div_t - {1'b0, cfg.period};
  assign d_neg   = (cfg.gain_d[31] == dneg_r);
  assign d_m     = ovf_r ? 57'h1_0000_0000
                         : ({25'd0, quo_r} + 57'(d_neg && (rem_r != '0)));

  assign sum33 = {acc_r[31], acc_r} + {incr_r[31], incr_r};
  assign il33  = $signed({2'b00, cfg.integral_limit});
  always_comb begin
    clamp_nxt = 1'b1;
    if (sum33 > il33)       acc_nxt = il33[31:0];
    else if (sum33 < -il33) acc_nxt = 32'(-il33);
    else begin
      acc_nxt   = sum33[31:0];
      clamp_nxt = 1'b0;
    end
  end

  assign drive34 = {{2{prop_r[31]}}, prop_r} + {{2{acc_r[31]}}, acc_r}
                 + {{2{deriv_r[31]}}, deriv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      prev_fb_r   <= '0;
    end else begin
      if (cmd.emit)      out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.load)             prev_fb_r <= in_word.feedback;
      if (cmd.op == OP_ACC_I)   acc_r     <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_r  <= sat_wide({diff33[32], diff33});
      dmag_r <= dmag;
      dneg_r <= delta33[32];
    end
    case (cmd.op)
      OP_CLAMP:  ec_r <= ec_nxt;
      OP_MUL_P:  prod_r <= mul_p;
      OP_FIN_P:  prop_r <= sat_mag(p_neg, p_m);
      OP_MUL_GE: begin
        prod_r   <= mul_p;
        ge_neg_r <= cfg.gain_i[31] ^ ec_r[31];
      end
      OP_MUL_LO: begin
        prod_r  <= mul_p;
        ge_hi_r <= prod_r[63:32];
      end
      OP_MUL_HI: begin
        prod_r <= mul_p;
        w_r    <= {32'd0, prod_r};
      end
      OP_ADD_HI: w_r[95:32] <= w_r[95:32] + prod_r;
      OP_FIN_I:  incr_r <= sat_mag(ge_neg_r, i_m);
      OP_ACC_I:  clamped_r <= clamp_nxt;
      OP_MUL_D:  prod_r <= mul_p;
      OP_DIV_PRE: begin
        ovf_r <= hi40 >= {8'd0, cfg.period};
        rem_r <= hi40[31:0];
        quo_r <= {prod_r[23:0], 8'd0};
      end
      OP_DIV_STEP: begin
        rem_r <= div_ge ? div_sub[31:0] : div_t[31:0];
        quo_r <= {quo_r[30:0], div_ge};
      end
      OP_FIN_D:  deriv_r <= sts.period_zero ? 32'sd0 : sat_mag(d_neg, d_m);
      default: ;
    endcase
    if (cmd.emit) begin
      out_word_r.drive            <= sat_wide(drive34);
      out_word_r.integral_term    <= acc_r;
      out_word_r.integral_clamped <= clamped_r;
    end
  end

  assign sts.period_zero = (cfg.period == '0);
  assign sts.out_full    = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_word        = out_word_r;

endmodule

`default_nettype wire

// ===== src/derivative_on_measurement_pid.sv =====
// Top level of the derivative-on-measurement PID: configuration registers,
// sequencer and datapath. Depends on dompid_pkg, dompid_ctrl, dompid_dpath.
//
//   port group   dir   handshake          word
//   in_*         in    in_valid/in_ready  in_word   (setpoint, feedback)
//   out_*        out   out_valid/out_ready out_word (drive, integral_term, integral_clamped)
//   cfg_*        in    cfg_wr_en          cfg_index, cfg_data
//
// Each word uses the single shared 32x32 multiplier and the 32-step restoring divider;
// the multiply and divide for the derivative are skipped when period is zero.
// A new word is taken the cycle after the result enters the output register,
// even while that result waits for out_ready.
// Synchronous active-low reset restores the register defaults and clears the
// integrator and the stored feedback.
`default_nettype none

module derivative_on_measurement_pid (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  dompid_pkg::in_word_t                 in_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output dompid_pkg::out_word_t                out_word,
  input  logic                                 cfg_wr_en,
  input  logic [dompid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dompid_pkg::VALUE_WIDTH-1:0]   cfg_data
);
  import dompid_pkg::*;

  cfg_regs_t cfg_r;
  cmd_t      cmd;
  sts_t      sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= RST_GAIN_P;
      cfg_r.gain_i         <= RST_GAIN_I;
      cfg_r.gain_d         <= RST_GAIN_D;
      cfg_r.period         <= RST_PERIOD;
      cfg_r.error_limit    <= RST_ERROR_LIMIT;
      cfg_r.integral_limit <= RST_INTEGRAL_LIMIT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GAIN_P:         cfg_r.gain_p         <= cfg_data;
        CFG_GAIN_I:         cfg_r.gain_i         <= cfg_data;
        CFG_GAIN_D:         cfg_r.gain_d         <= cfg_data;
        CFG_PERIOD:         cfg_r.period         <= cfg_data;
        CFG_ERROR_LIMIT:    cfg_r.error_limit    <= cfg_data[LIMIT_WIDTH-1:0];
        CFG_INTEGRAL_LIMIT: cfg_r.integral_limit <= cfg_data[LIMIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  dompid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dompid_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== src/dompid_checker.sv =====
// Port-level checks for derivative_on_measurement_pid, attached by bind.
// Depends on dompid_pkg and the top level's ports.
`default_nettype none

module dompid_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input dompid_pkg::out_word_t out_word
);
  import dompid_pkg::*;

  // reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

  // one word at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too soon after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result changed");

endmodule

bind derivative_on_measurement_pid dompid_checker u_dompid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

`default_nettype wire
